// File: rtl/core/wl_ctrl_pkg.sv
// wl_ctrl_pkg: mode, request, lamp and register index codes for the window lifter controller.
// No dependencies; imported by window_lifter_controller.
package wl_ctrl_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BLOCK   = 3'd1,
    MODE_PINCH   = 3'd2,
    MODE_UP_AUTO = 3'd3,
    MODE_UP_MAN  = 3'd4,
    MODE_DN_AUTO = 3'd5,
    MODE_DN_MAN  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_AUTO  = 2'd1,
    REQ_MAN   = 2'd2,
    REQ_PINCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    LAMP_OFF  = 2'd0,
    LAMP_UP   = 2'd1,
    LAMP_DOWN = 2'd2
  } lamp_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_HOLD   = 3'd0,
    CFG_MANUAL_HOLD = 3'd1,
    CFG_PINCH_HOLD  = 3'd2,
    CFG_HOLD_CEIL   = 3'd3,
    CFG_STEP_INTVL  = 3'd4,
    CFG_PINCH_WAIT  = 3'd5
  } cfg_idx_t;

endpackage

// File: rtl/core/window_lifter_controller.sv
// window_lifter_controller: power window lifter with anti-pinch, one tick per input beat.
// Depends on wl_ctrl_pkg (mode, request, lamp and register index codes).
//
//   channel | ports                                              | dir
//   in      | in_valid, in_ready, in_up/down_pressed, in_pinch   | beat in, one per tick
//   out     | out_valid, out_ready, out_window_position/lamp/mode| beat out, one per tick
//   cfg     | cfg_we, cfg_idx, cfg_wdata                         | register write, no wait
//
// Each input beat is folded into the state and its result is loaded into the output
// register on the same edge; one beat per cycle is sustained while out_ready is high.
// The output register is the only buffer: in_ready drops only while a result is held
// with out_ready low. Reset (rst_n low, synchronous) clears the controller state and
// out_valid and loads the register defaults with no clearing pass; payload is not reset.
module window_lifter_controller #(
  parameter int unsigned POSITION_STEPS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_up_pressed,
  input  logic                               in_down_pressed,
  input  logic                               in_pinch_sensed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [$clog2(POSITION_STEPS+1)-1:0] out_window_position,
  output logic [1:0]                         out_direction_lamp,
  output logic [2:0]                         out_mode,
  input  logic                               cfg_we,
  input  logic [wl_ctrl_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [wl_ctrl_pkg::CfgW-1:0]       cfg_wdata
);
  import wl_ctrl_pkg::*;

  localparam int unsigned PosW = $clog2(POSITION_STEPS + 1);
  localparam logic [PosW-1:0] PosTop = PosW'(POSITION_STEPS);

  function automatic logic [CfgW-1:0] sat_inc(input logic [CfgW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  // configuration
  logic [CfgW-1:0] auto_hold_r, manual_hold_r, pinch_hold_cfg_r;
  logic [CfgW-1:0] ceil_r, step_intvl_r, pinch_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_hold_r      <= CfgW'(10);
      manual_hold_r    <= CfgW'(500);
      pinch_hold_cfg_r <= CfgW'(10);
      ceil_r           <= CfgW'(600);
      step_intvl_r     <= CfgW'(200);
      pinch_wait_r     <= CfgW'(2500);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_AUTO_HOLD:   auto_hold_r      <= cfg_wdata;
        CFG_MANUAL_HOLD: manual_hold_r    <= cfg_wdata;
        CFG_PINCH_HOLD:  pinch_hold_cfg_r <= cfg_wdata;
        CFG_HOLD_CEIL:   ceil_r           <= cfg_wdata;
        CFG_STEP_INTVL:  step_intvl_r     <= cfg_wdata;
        CFG_PINCH_WAIT:  pinch_wait_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // controller state
  mode_t           mode_r, mode_nxt;
  req_t            req_r, req_nxt;
  lamp_t           lamp_r, lamp_nxt;
  logic [CfgW-1:0] up_hold_r, up_hold_nxt, dn_hold_r, dn_hold_nxt;
  logic [CfgW-1:0] pinch_hold_r, pinch_hold_nxt;
  logic [CfgW-1:0] step_tmr_r, step_tmr_nxt, wait_tmr_r, wait_tmr_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            sel_dn_r, sel_dn_nxt;
  logic            slow_r;
  logic            out_valid_r;
  logic [PosW-1:0] out_pos_r;
  lamp_t           out_lamp_r;
  mode_t           out_mode_r;

  logic            in_fire;
  logic [CfgW-1:0] hold_sel;
  logic            do_move, move_up, is_open, is_closed;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    mode_nxt       = mode_r;
    req_nxt        = req_r;
    lamp_nxt       = lamp_r;
    up_hold_nxt    = up_hold_r;
    dn_hold_nxt    = dn_hold_r;
    pinch_hold_nxt = pinch_hold_r;
    step_tmr_nxt   = step_tmr_r;
    wait_tmr_nxt   = wait_tmr_r;
    pos_nxt        = pos_r;
    sel_dn_nxt     = sel_dn_r;
    do_move        = 1'b0;
    move_up        = 1'b0;
    is_open        = (pos_r == '0);
    is_closed      = (pos_r == PosTop);

    // button levels
    if (mode_r != MODE_PINCH && (in_up_pressed ^ in_down_pressed)) begin
      sel_dn_nxt = in_down_pressed;
      if (in_down_pressed) dn_hold_nxt = sat_inc(dn_hold_r);
      else                 up_hold_nxt = sat_inc(up_hold_r);
    end else begin
      up_hold_nxt = '0;
      dn_hold_nxt = '0;
      if (in_up_pressed && in_down_pressed) mode_nxt = MODE_IDLE;
    end
    if ((mode_nxt == MODE_UP_AUTO || mode_nxt == MODE_UP_MAN) && in_pinch_sensed)
      pinch_hold_nxt = sat_inc(pinch_hold_r);
    else
      pinch_hold_nxt = '0;

    // hold time qualification; the selected count backs off above the ceiling
    hold_sel = sel_dn_nxt ? dn_hold_nxt : up_hold_nxt;
    if (pinch_hold_nxt > pinch_hold_cfg_r) begin
      req_nxt = REQ_PINCH;
    end else if (hold_sel == auto_hold_r) begin
      req_nxt = REQ_AUTO;
    end else if (hold_sel == manual_hold_r) begin
      req_nxt = REQ_MAN;
    end else begin
      if (hold_sel < auto_hold_r) req_nxt = REQ_NONE;
      if (hold_sel > ceil_r) begin
        if (sel_dn_nxt) dn_hold_nxt = hold_sel - 1'b1;
        else            up_hold_nxt = hold_sel - 1'b1;
      end
    end

    if (slow_r) begin
      // mode manager
      case (req_nxt)
        REQ_AUTO: begin
          if (mode_nxt == MODE_IDLE) mode_nxt = sel_dn_nxt ? MODE_DN_AUTO : MODE_UP_AUTO;
          else                       mode_nxt = MODE_BLOCK;
        end
        REQ_MAN: begin
          if (mode_nxt == MODE_UP_AUTO || mode_nxt == MODE_DN_AUTO)
            mode_nxt = sel_dn_nxt ? MODE_DN_MAN : MODE_UP_MAN;
        end
        REQ_PINCH: begin
          if (mode_nxt == MODE_UP_AUTO || mode_nxt == MODE_UP_MAN) mode_nxt = MODE_PINCH;
        end
        default: ;
      endcase
      req_nxt = REQ_NONE;

      // mode response
      case (mode_nxt)
        MODE_BLOCK: begin
          if (!(sel_dn_nxt ? in_down_pressed : in_up_pressed)) mode_nxt = MODE_IDLE;
          lamp_nxt = LAMP_OFF;
        end
        MODE_IDLE: lamp_nxt = LAMP_OFF;
        MODE_PINCH: begin
          if (!is_open) begin
            do_move = 1'b1;
          end else begin
            if (wait_tmr_r == pinch_wait_r) begin
              mode_nxt     = MODE_IDLE;
              wait_tmr_nxt = CfgW'(1);
            end else begin
              wait_tmr_nxt = wait_tmr_r + 1'b1;
            end
            lamp_nxt = LAMP_OFF;
          end
        end
        MODE_UP_AUTO: begin
          if (!is_closed) begin
            do_move = 1'b1;
            move_up = 1'b1;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_UP_MAN: begin
          if (!is_closed && in_up_pressed && !in_down_pressed) begin
            do_move = 1'b1;
            move_up = 1'b1;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_DN_AUTO: begin
          if (!is_open) do_move = 1'b1;
          else          mode_nxt = MODE_IDLE;
        end
        MODE_DN_MAN: begin
          if (!is_open && in_down_pressed && !in_up_pressed) do_move = 1'b1;
          else                                               mode_nxt = MODE_IDLE;
        end
        default: ;
      endcase

      // one timed move; the move count restarts at 1 after each position step
      if (do_move) begin
        if (step_tmr_r == step_intvl_r) begin
          if (move_up) pos_nxt = pos_r + 1'b1;
          else         pos_nxt = pos_r - 1'b1;
          step_tmr_nxt = CfgW'(1);
        end else begin
          step_tmr_nxt = step_tmr_r + 1'b1;
        end
        lamp_nxt = move_up ? LAMP_UP : LAMP_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      req_r        <= REQ_NONE;
      lamp_r       <= LAMP_OFF;
      up_hold_r    <= '0;
      dn_hold_r    <= '0;
      pinch_hold_r <= '0;
      step_tmr_r   <= '0;
      wait_tmr_r   <= '0;
      pos_r        <= '0;
      sel_dn_r     <= 1'b0;
      slow_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r       <= mode_nxt;
        req_r        <= req_nxt;
        lamp_r       <= lamp_nxt;
        up_hold_r    <= up_hold_nxt;
        dn_hold_r    <= dn_hold_nxt;
        pinch_hold_r <= pinch_hold_nxt;
        step_tmr_r   <= step_tmr_nxt;
        wait_tmr_r   <= wait_tmr_nxt;
        pos_r        <= pos_nxt;
        sel_dn_r     <= sel_dn_nxt;
        slow_r       <= !slow_r;
      end
      if (in_fire)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pos_r  <= pos_nxt;
      out_lamp_r <= lamp_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_window_position = out_pos_r;
  assign out_direction_lamp  = out_lamp_r;
  assign out_mode            = out_mode_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosTop) else $error("window position beyond fully closed");

  a_slow_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> slow_r != $past(slow_r)) else $error("slow phase did not toggle");

  a_pos_fast_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !slow_r |=> pos_r == $past(pos_r)) else $error("position moved off a slow step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && out_pos_r == pos_r && out_mode_r == mode_r)
    else $error("result register does not match state");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= MODE_DN_MAN)
    else $error("mode register holds the unused code");

endmodule
